>>> hdl/xmct_pkg.sv
package xmct_pkg;

    localparam int VALUE_BITS = 16;
    localparam int VALUE_W    = 16;
    localparam int MEX_W      = 17;
    localparam int NODE_BITS  = VALUE_BITS + 1;
    localparam int CNT_W      = VALUE_BITS + 1;
    localparam int LVL_W      = (VALUE_BITS > 2) ? $clog2(VALUE_BITS) : 1;
    localparam int NODE_COUNT = 2 ** NODE_BITS;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    typedef logic [VALUE_BITS-1:0] val_t;
    typedef logic [NODE_BITS-1:0]  node_t;
    typedef logic [CNT_W-1:0]      cnt_t;
    typedef logic [LVL_W-1:0]      lvl_t;

    typedef struct packed {
        logic clr;
        logic ins_load;
        logic qry_load;
        logic ins_read;
        logic ins_step;
        logic root_read;
        logic q_start;
        logic q_step;
    } cmd_t;

    typedef struct packed {
        logic clr_done;
        logic leaf_present;
        logic at_root;
        logic full;
        logic q_end;
    } stat_t;

    function automatic val_t to_val(input logic [VALUE_W-1:0] v);
        logic [VALUE_BITS+VALUE_W-1:0] w;
        w = {{VALUE_BITS{1'b0}}, v};
        return w[VALUE_BITS-1:0];
    endfunction

    function automatic logic [MEX_W-1:0] to_mex(input cnt_t r);
        logic [CNT_W+MEX_W-1:0] w;
        w = {{MEX_W{1'b0}}, r};
        return w[MEX_W-1:0];
    endfunction

endpackage

>>> hdl/xor_mex_count_trie_top.sv
// Set of distinct 16-bit values with a running xor key and a mex query. After reset the
// count memory (2^17 entries) is cleared one entry per cycle, so busy stays high until the
// last entry is cleared. A transaction is taken when start is high and busy is low. An
// insert (opcode 0) walks the count tree from leaf to root with one read-modify-write per
// level on the single count memory, and stops after the leaf read when the value is already
// present; it gives no result. A query (opcode 1) xors value into the key and walks from the
// root down, one level per cycle with both children read from the memory's two read ports,
// and the walk can stop early. Its mex shows on mex with done high for exactly one cycle, in
// the last busy cycle; the receiver cannot stall and must take it then.
module xor_mex_count_trie_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          opcode,
    input  logic [xmct_pkg::VALUE_W-1:0]  value,
    output logic                          done,
    output logic [xmct_pkg::MEX_W-1:0]    mex
);

    xmct_pkg::cmd_t  cmd;
    xmct_pkg::stat_t stat;

    xmct_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .opcode (opcode),
        .stat   (stat),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    xmct_dp u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .value  (value),
        .cmd    (cmd),
        .stat   (stat),
        .mex    (mex)
    );

endmodule

>>> hdl/xmct_ctrl.sv
module xmct_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                opcode,
    input  xmct_pkg::stat_t     stat,
    output xmct_pkg::cmd_t      cmd,
    output logic                busy,
    output logic                done
);

    localparam logic [3:0] S_CLEAR   = 4'd0;
    localparam logic [3:0] S_IDLE    = 4'd1;
    localparam logic [3:0] S_INS_RD  = 4'd2;
    localparam logic [3:0] S_INS_CHK = 4'd3;
    localparam logic [3:0] S_INS_UP  = 4'd4;
    localparam logic [3:0] S_Q_ROOT  = 4'd5;
    localparam logic [3:0] S_Q_FULL  = 4'd6;
    localparam logic [3:0] S_Q_LVL   = 4'd7;
    localparam logic [3:0] S_OUT     = 4'd8;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clr = 1'b1;
                if (stat.clr_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    if (opcode == xmct_pkg::OP_QUERY)
                    begin
                        cmd.qry_load = 1'b1;
                        state_next   = S_Q_ROOT;
                    end
                    else
                    begin
                        cmd.ins_load = 1'b1;
                        state_next   = S_INS_RD;
                    end
                end
            end
            S_INS_RD:
            begin
                cmd.ins_read = 1'b1;
                state_next   = S_INS_CHK;
            end
            S_INS_CHK:
            begin
                // a value already present leaves the counts alone
                if (stat.leaf_present)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.ins_step = 1'b1;
                    state_next   = S_INS_UP;
                end
            end
            S_INS_UP:
            begin
                cmd.ins_step = 1'b1;
                if (stat.at_root)
                begin
                    state_next = S_IDLE;
                end
            end
            S_Q_ROOT:
            begin
                cmd.root_read = 1'b1;
                state_next    = S_Q_FULL;
            end
            S_Q_FULL:
            begin
                cmd.q_start = 1'b1;
                state_next  = stat.full ? S_OUT : S_Q_LVL;
            end
            S_Q_LVL:
            begin
                cmd.q_step = 1'b1;
                if (stat.q_end)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_OUT);

endmodule

>>> hdl/xmct_dp.sv
module xmct_dp (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [xmct_pkg::VALUE_W-1:0]      value,
    input  xmct_pkg::cmd_t                    cmd,
    output xmct_pkg::stat_t                   stat,
    output logic [xmct_pkg::MEX_W-1:0]        mex
);

    localparam int NB = xmct_pkg::NODE_BITS;
    localparam int LW = xmct_pkg::LVL_W;

    xmct_pkg::cnt_t  cnt_mem_reg [0:xmct_pkg::NODE_COUNT-1];

    xmct_pkg::val_t  key_reg;
    xmct_pkg::node_t node_reg;
    xmct_pkg::lvl_t  lvl_reg;
    xmct_pkg::cnt_t  result_reg;
    xmct_pkg::node_t clr_addr_reg;
    xmct_pkg::cnt_t  rda_reg;
    xmct_pkg::cnt_t  rdb_reg;

    xmct_pkg::node_t rd_addr_a;
    xmct_pkg::node_t rd_addr_b;
    xmct_pkg::node_t wr_addr;
    xmct_pkg::cnt_t  wr_data;
    logic            wr_en;

    logic            kb;
    logic            kb_nx;
    xmct_pkg::lvl_t  lvl_m1;
    xmct_pkg::cnt_t  pow;
    logic            stop0;
    logic            go_same;
    logic            stop1;
    xmct_pkg::node_t node_nx;
    xmct_pkg::node_t node_up;

    assign kb      = key_reg[lvl_reg];
    assign lvl_m1  = lvl_reg - LW'(1);
    assign kb_nx   = key_reg[lvl_m1];
    assign pow     = xmct_pkg::CNT_W'(1) << lvl_reg;
    assign stop0   = (rda_reg == '0);
    assign go_same = (rda_reg < pow);
    // full subtree on the key side and an empty other side: result bit is 1, the walk stops
    assign stop1   = !go_same && (rdb_reg == '0);
    assign node_nx = {node_reg[NB-2:0], go_same ? kb : ~kb};
    assign node_up = node_reg >> 1;

    always_comb
    begin
        rd_addr_a = node_reg;
        rd_addr_b = node_reg;
        if (cmd.root_read)
        begin
            rd_addr_a = NB'(1);
        end
        else if (cmd.ins_read)
        begin
            rd_addr_a = node_reg;
        end
        else if (cmd.ins_step)
        begin
            rd_addr_a = node_up;
        end
        else if (cmd.q_start)
        begin
            rd_addr_a = {node_reg[NB-2:0], kb};
            rd_addr_b = {node_reg[NB-2:0], ~kb};
        end
        else if (cmd.q_step)
        begin
            rd_addr_a = {node_nx[NB-2:0], kb_nx};
            rd_addr_b = {node_nx[NB-2:0], ~kb_nx};
        end
    end

    assign wr_en   = cmd.clr | cmd.ins_step;
    assign wr_addr = cmd.clr ? clr_addr_reg : node_reg;
    assign wr_data = cmd.clr ? '0 : rda_reg + xmct_pkg::CNT_W'(1);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            cnt_mem_reg[wr_addr] <= wr_data;
        end
        rda_reg <= cnt_mem_reg[rd_addr_a];
        rdb_reg <= cnt_mem_reg[rd_addr_b];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg      <= '0;
            clr_addr_reg <= '0;
        end
        else
        begin
            if (cmd.clr)
            begin
                clr_addr_reg <= clr_addr_reg + NB'(1);
            end
            if (cmd.qry_load)
            begin
                key_reg <= key_reg ^ xmct_pkg::to_val(value);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ins_load)
        begin
            node_reg <= {1'b1, xmct_pkg::to_val(value)};
        end
        else if (cmd.qry_load)
        begin
            node_reg   <= NB'(1);
            result_reg <= '0;
            lvl_reg    <= LW'(xmct_pkg::VALUE_BITS - 1);
        end
        else if (cmd.ins_step)
        begin
            node_reg <= node_up;
        end
        else if (cmd.q_start)
        begin
            if (stat.full)
            begin
                result_reg <= xmct_pkg::CNT_W'(1) << xmct_pkg::VALUE_BITS;
            end
        end
        else if (cmd.q_step)
        begin
            if (!stop0)
            begin
                if (!go_same)
                begin
                    result_reg[lvl_reg] <= 1'b1;
                end
                node_reg <= node_nx;
            end
            lvl_reg <= lvl_m1;
        end
    end

    assign stat.clr_done     = (clr_addr_reg == '1);
    assign stat.leaf_present = (rda_reg != '0);
    assign stat.at_root      = (node_reg == NB'(1));
    assign stat.full         = rda_reg[xmct_pkg::VALUE_BITS];
    assign stat.q_end        = stop0 | stop1 | (lvl_reg == '0);

    assign mex = xmct_pkg::to_mex(result_reg);

endmodule

>>> hdl/xmct_checker.sv
module xmct_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          start,
    input logic                          busy,
    input logic                          opcode,
    input logic                          done,
    input logic [xmct_pkg::MEX_W-1:0]    mex
);

    logic accept;
    assign accept = start && !busy;

    // results only come out while a query is still in flight
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("done without busy");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done longer than one cycle");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy && !done)
        else $error("accepted transaction did not raise busy");

    a_mex_range: assert property (@(posedge clk) disable iff (!rst_n)
        (done && mex[xmct_pkg::MEX_W-1]) |-> (mex[xmct_pkg::MEX_W-2:0] == '0))
        else $error("mex above full set value");

    a_insert_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !opcode) |=> ##1 !done)
        else $error("insert produced a result");

endmodule

bind xor_mex_count_trie_top xmct_checker u_xmct_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .opcode (opcode),
    .done   (done),
    .mex    (mex)
);

>>> tb/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic           op;
        xmct_pkg::val_t val;
        bit             may_idle;
    } txn_t;

    bit                                clk;
    logic                              rst_n;
    logic                              start;
    logic                              busy;
    logic                              opcode;
    logic [xmct_pkg::VALUE_W-1:0]      value;
    logic                              done;
    logic [xmct_pkg::MEX_W-1:0]        mex;

    txn_t                              pending_txns [$];
    logic [xmct_pkg::MEX_W-1:0]        mex_expect [$];
    bit [xmct_pkg::CNT_W-1:0]          tree_count [xmct_pkg::NODE_COUNT];
    xmct_pkg::val_t                    model_key;
    logic                              took;
    int                                gap_left;
    int                                errors;

    // stimulus-side view of the set and key, used to build targeted queries and repeat inserts
    bit                                gen_seen [1 << xmct_pkg::VALUE_BITS];
    xmct_pkg::val_t                    gen_stored [$];
    xmct_pkg::val_t                    gen_key;
    int                                fresh;

    xor_mex_count_trie_top dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .opcode (opcode),
        .value  (value),
        .done   (done),
        .mex    (mex)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    initial
    begin
        #25_000_000;
        $display("testbench: errors");
        $finish;
    end

    // add a value to the count tree, leaf to root; a present value changes nothing
    function automatic void record_insert(input xmct_pkg::val_t v);
        int n;
        n = (1 << xmct_pkg::VALUE_BITS) | int'(v);
        if (tree_count[n] != 0)
            return;
        while (n >= 1)
        begin
            tree_count[n] = tree_count[n] + xmct_pkg::cnt_t'(1);
            n = n >> 1;
        end
    endfunction

    function automatic logic [xmct_pkg::MEX_W-1:0] smallest_absent(input xmct_pkg::val_t k);
        logic [xmct_pkg::MEX_W-1:0] r;
        int n;
        int b;
        int same;
        int other;
        r = '0;
        n = 1;
        if (tree_count[1] >= (1 << xmct_pkg::VALUE_BITS))
        begin
            r[xmct_pkg::VALUE_BITS] = 1'b1;
            return r;
        end
        for (b = xmct_pkg::VALUE_BITS - 1; b >= 0; b--)
        begin
            same = (n << 1) | int'(k[b]);
            if (tree_count[same] == 0)
                break;
            if (tree_count[same] < (1 << b))
                n = same;
            else
            begin
                // key side is full, so this bit of the mex must be 1
                other = (n << 1) | int'(!k[b]);
                r[b] = 1'b1;
                if (tree_count[other] == 0)
                    break;
                n = other;
            end
        end
        return r;
    endfunction

    task automatic push_insert(input xmct_pkg::val_t v, input bit idle);
        txn_t t;
        t.op = xmct_pkg::OP_INSERT;
        t.val = v;
        t.may_idle = idle;
        pending_txns.insert(pending_txns.size(), t);
        if (!gen_seen[v])
        begin
            gen_seen[v] = 1'b1;
            gen_stored.insert(gen_stored.size(), v);
            fresh++;
        end
    endtask

    task automatic push_query(input xmct_pkg::val_t delta, input bit idle);
        txn_t t;
        t.op = xmct_pkg::OP_QUERY;
        t.val = delta;
        t.may_idle = idle;
        pending_txns.insert(pending_txns.size(), t);
        gen_key = gen_key ^ delta;
        fresh++;
    endtask

    // driver
    always @(negedge clk)
    begin
        txn_t item;
        if (!rst_n)
        begin
            start <= 1'b0;
            opcode <= xmct_pkg::OP_INSERT;
            value <= '0;
            gap_left <= 0;
        end
        else if (start && !took)
        begin
            // hold the transaction until it is taken
        end
        else if (gap_left != 0)
        begin
            start <= 1'b0;
            opcode <= 1'($urandom);
            value <= xmct_pkg::val_t'($urandom);
            gap_left <= gap_left - 1;
        end
        else if (pending_txns.size() != 0)
        begin
            item = pending_txns.pop_front();
            start <= 1'b1;
            opcode <= item.op;
            value <= item.val;
            if (item.may_idle && $urandom_range(0, 2) == 0)
                gap_left <= $urandom_range(1, 14);
        end
        else
            start <= 1'b0;
    end

    // monitor and checker
    always @(posedge clk)
    begin
        logic [xmct_pkg::MEX_W-1:0] want;
        if (!rst_n)
        begin
            took <= 1'b0;
            model_key = '0;
        end
        else
        begin
            took <= start && !busy;
            if (done === 1'b1)
            begin
                if (mex_expect.size() == 0)
                begin
                    $display("%0t: mex %0d with no query outstanding", $realtime, mex);
                    errors++;
                end
                else
                begin
                    want = mex_expect.pop_front();
                    if (mex !== want)
                    begin
                        $display("%0t: mex mismatch: expected %0d, actual %0d",
                                 $realtime, want, mex);
                        errors++;
                    end
                end
            end
            if (start && !busy)
            begin
                if (opcode == xmct_pkg::OP_INSERT)
                    record_insert(value);
                else
                begin
                    model_key = model_key ^ value;
                    mex_expect.insert(mex_expect.size(), smallest_absent(model_key));
                end
            end
        end
    end

    initial
    begin
        int i;
        int n;
        int sz;
        int kind;
        bit idle_ok;
        xmct_pkg::val_t base;
        xmct_pkg::val_t target;

        rst_n = 1'b0;
        gen_key = '0;
        fresh = 0;

        // empty set, both key extremes, duplicates, top and bottom values
        push_query(16'h0000, 1);
        push_query(16'hFFFF, 1);
        push_insert(16'h0000, 1);
        push_insert(16'hFFFF, 1);
        push_insert(16'hFFFF, 1);
        push_insert(16'h0000, 1);
        push_query(16'hFFFF, 1);
        push_insert(16'h0001, 1);
        push_insert(16'h0002, 1);
        push_insert(16'h0003, 1);
        push_query(16'h0000, 1);
        push_query(16'hFFFF, 1);
        push_insert(16'h8000, 1);
        push_insert(16'h7FFF, 1);
        push_query(16'h7FFF, 1);
        push_insert(16'hAAAA, 1);
        push_insert(16'h5555, 1);
        push_query(16'hAAAA, 1);
        push_query(16'h5555, 1);

        while (fresh < 850)
        begin
            // no idling in the last part of the run
            idle_ok = (fresh < 700) && ($urandom_range(0, 3) != 0);
            kind = $urandom_range(0, 9);
            if (kind <= 5)
            begin
                // aligned run with a few holes, then queries keyed near its base
                sz = ($urandom_range(0, 7) == 0) ? 128 : $urandom_range(1, 64);
                base = xmct_pkg::val_t'($urandom);
                base[6:0] = '0;
                for (i = 0; i < sz; i++)
                    if ($urandom_range(0, 15) != 0)
                        push_insert(xmct_pkg::val_t'(base + i), idle_ok);
                n = $urandom_range(1, 3);
                for (i = 0; i < n; i++)
                begin
                    target = base;
                    if ($urandom_range(0, 1) == 0)
                        target[6:0] = 7'($urandom_range(0, 127));
                    push_query(gen_key ^ target, idle_ok);
                end
            end
            else if (kind <= 7)
            begin
                n = $urandom_range(1, 4);
                for (i = 0; i < n; i++)
                    if ($urandom_range(0, 1) == 0)
                        push_insert(xmct_pkg::val_t'($urandom), idle_ok);
                    else
                        push_query(xmct_pkg::val_t'($urandom), idle_ok);
            end
            else if (kind == 8)
            begin
                if (gen_stored.size() != 0)
                    push_insert(gen_stored[$urandom_range(0, gen_stored.size() - 1)],
                                idle_ok);
            end
            else
                push_query(xmct_pkg::val_t'(1) << $urandom_range(0, xmct_pkg::VALUE_BITS - 1),
                           idle_ok);
        end

        push_query(16'h0000, 0);
        push_query(xmct_pkg::val_t'($urandom), 0);
        push_query(16'hFFFF, 0);

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (pending_txns.size() != 0 || start)
            @(posedge clk);
        while (mex_expect.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        if (errors == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
